/* rtl/core/wsdf_pkg.sv */
`default_nettype none

package wsdf_pkg;

   // parser phase codes
   localparam logic [2:0] PH_FIRST = 3'd0;
   localparam logic [2:0] PH_LEN   = 3'd1;
   localparam logic [2:0] PH_EXT   = 3'd2;
   localparam logic [2:0] PH_KEY   = 3'd3;
   localparam logic [2:0] PH_PAY   = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_HDR  = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_PAY  = 2'd2;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic        final_flag;
      logic [3:0]  frame_opcode;
      logic        masked;
      logic [63:0] frame_length;
      logic        frame_end;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/websocket_frame_deframer.sv */
`default_nettype none

// WebSocket (RFC 6455) receive-side frame parser.
// Request channel: req_valid/req_stall with req_rx_byte, one stream byte per
// request. Response channel: rsp_valid/rsp_stall, exactly one response per
// request, in order: header byte consumed, header complete, or unmasked
// payload byte, with the frame's FIN, opcode, mask flag and length so far.
// rsp_frame_end marks the last payload byte, or the header of an empty frame.
// A response is registered in the output register, or in the skid register
// if that holds a stalled response. Throughput: one byte per cycle while
// req_stall is low; state and response come from one pass of logic per byte.
// The output register is backed by a one-entry skid register, so a request is
// still taken while a response waits; req_stall rises only once the skid
// register is occupied, i.e. after the receiver has stalled with two
// responses pending, and it depends on registers alone.
// Reset (synchronous, active high) empties both registers and returns the
// parser to expecting the first header byte of a frame.

module websocket_frame_deframer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_final_flag,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_masked,
   output logic [63:0] rsp_frame_length,
   output logic        rsp_frame_end
);

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  field_count_ff, field_count_in;
   logic [63:0] length_ff, length_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_pos_ff, mask_pos_in;
   logic        mask_flag_ff, mask_flag_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;

   wsdf_pkg::result_type res_in;
   wsdf_pkg::result_type out_ff;
   wsdf_pkg::result_type skid_ff;
   logic                 out_valid_ff;
   logic                 skid_valid_ff;

   logic req_acc;
   logic rsp_take;

   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   // per-byte parse step
   always_comb begin
      logic [1:0]  kind;
      logic [7:0]  pay;
      logic        fend;
      logic [3:0]  fc_dec;
      logic [63:0] rem_dec;
      logic [7:0]  key_byte;
      logic        len_known;
      logic        hdr_done;

      phase_in       = phase_ff;
      field_count_in = field_count_ff;
      length_in      = length_ff;
      remaining_in   = remaining_ff;
      mask_key_in    = mask_key_ff;
      mask_pos_in    = mask_pos_ff;
      mask_flag_in   = mask_flag_ff;
      fin_in         = fin_ff;
      opcode_in      = opcode_ff;
      kind           = wsdf_pkg::KIND_HDR;
      pay            = 8'd0;
      fend           = 1'b0;
      len_known      = 1'b0;
      hdr_done       = 1'b0;
      fc_dec         = (field_count_ff != 4'd0) ? field_count_ff - 4'd1 : field_count_ff;
      rem_dec        = (remaining_ff != 64'd0) ? remaining_ff - 64'd1 : remaining_ff;

      case (mask_pos_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase

      case (phase_ff)
         wsdf_pkg::PH_LEN: begin
            mask_flag_in = req_rx_byte[7];
            if (req_rx_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
               field_count_in = wsdf_pkg::EXT16_BYTES;
               length_in      = 64'd0;
               phase_in       = wsdf_pkg::PH_EXT;
            end else if (req_rx_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
               field_count_in = wsdf_pkg::EXT64_BYTES;
               length_in      = 64'd0;
               phase_in       = wsdf_pkg::PH_EXT;
            end else begin
               length_in = {57'd0, req_rx_byte[6:0]};
               len_known = 1'b1;
            end
         end
         wsdf_pkg::PH_EXT: begin
            length_in      = {length_ff[55:0], req_rx_byte};
            field_count_in = fc_dec;
            len_known      = (fc_dec == 4'd0);
         end
         wsdf_pkg::PH_KEY: begin
            mask_key_in    = {mask_key_ff[23:0], req_rx_byte};
            field_count_in = fc_dec;
            hdr_done       = (fc_dec == 4'd0);
         end
         wsdf_pkg::PH_PAY: begin
            pay          = mask_flag_ff ? (req_rx_byte ^ key_byte) : req_rx_byte;
            mask_pos_in  = mask_pos_ff + 2'd1;
            kind         = wsdf_pkg::KIND_PAY;
            remaining_in = rem_dec;
            if (rem_dec == 64'd0) begin
               fend     = 1'b1;
               phase_in = wsdf_pkg::PH_FIRST;
            end
         end
         default: begin
            fin_in         = req_rx_byte[7];
            opcode_in      = req_rx_byte[3:0];
            mask_flag_in   = 1'b0;
            length_in      = 64'd0;
            remaining_in   = 64'd0;
            field_count_in = 4'd0;
            phase_in       = wsdf_pkg::PH_LEN;
         end
      endcase

      // mask flag from the second header byte decides whether the key follows
      if (len_known) begin
         if (mask_flag_in) begin
            field_count_in = wsdf_pkg::KEY_BYTES;
            mask_key_in    = 32'd0;
            phase_in       = wsdf_pkg::PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         kind = wsdf_pkg::KIND_DONE;
         if (length_in == 64'd0) begin
            fend     = 1'b1;
            phase_in = wsdf_pkg::PH_FIRST;
         end else begin
            remaining_in = length_in;
            mask_pos_in  = 2'd0;
            phase_in     = wsdf_pkg::PH_PAY;
         end
      end

      res_in.kind         = kind;
      res_in.payload_byte = pay;
      res_in.final_flag   = fin_in;
      res_in.frame_opcode = opcode_in;
      res_in.masked       = mask_flag_in;
      res_in.frame_length = length_in;
      res_in.frame_end    = fend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= wsdf_pkg::PH_FIRST;
         field_count_ff <= 4'd0;
         length_ff      <= 64'd0;
         remaining_ff   <= 64'd0;
         mask_key_ff    <= 32'd0;
         mask_pos_ff    <= 2'd0;
         mask_flag_ff   <= 1'b0;
         fin_ff         <= 1'b0;
         opcode_ff      <= 4'd0;
      end else if (req_acc) begin
         phase_ff       <= phase_in;
         field_count_ff <= field_count_in;
         length_ff      <= length_in;
         remaining_ff   <= remaining_in;
         mask_key_ff    <= mask_key_in;
         mask_pos_ff    <= mask_pos_in;
         mask_flag_ff   <= mask_flag_in;
         fin_ff         <= fin_in;
         opcode_ff      <= opcode_in;
      end
   end

   // output register with skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_acc) begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_ff <= skid_ff;
         end
      end else if (req_acc) begin
         if (!out_valid_ff || rsp_take) begin
            out_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_final_flag   = out_ff.final_flag;
   assign rsp_frame_opcode = out_ff.frame_opcode;
   assign rsp_masked       = out_ff.masked;
   assign rsp_frame_length = out_ff.frame_length;
   assign rsp_frame_end    = out_ff.frame_end;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_pay_phase_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsdf_pkg::PH_PAY |-> remaining_ff != 64'd0)
      else $error("payload phase with no bytes remaining");

   a_non_pay_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind != wsdf_pkg::KIND_PAY |-> out_ff.payload_byte == 8'd0)
      else $error("payload byte set on a header response");

   a_empty_frame_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.frame_end && out_ff.kind == wsdf_pkg::KIND_DONE
      |-> out_ff.frame_length == 64'd0)
      else $error("header marked as frame end with non-zero length");

   a_stall_held_out: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_take |=> out_valid_ff && $stable(out_ff))
      else $error("stalled response changed");
`endif

endmodule

`default_nettype wire
